// ===== hdl/sack_pkg.sv =====
`default_nettype none
package sack_pkg;
	localparam logic [2:0] FUNC_INIT    = 3'd0;
	localparam logic [2:0] FUNC_ADD     = 3'd1;
	localparam logic [2:0] FUNC_ADVANCE = 3'd2;
	localparam logic [2:0] FUNC_QUERY   = 3'd3;
	localparam logic [2:0] FUNC_HOLES   = 3'd4;
	localparam logic [2:0] RESULT_CAP   = 3'd4;

	// datapath commands, one per cycle from the controller
	typedef enum logic [3:0] {
		CMD_NONE    = 4'd0,
		CMD_LOAD    = 4'd1,  // latch the input item
		CMD_INIT    = 4'd2,
		CMD_INSERT  = 4'd3,  // store the new range
		CMD_SORT    = 4'd4,  // one odd-even transposition pass
		CMD_MERGE   = 4'd5,  // fold one slot into the write slot
		CMD_FRONT   = 4'd6,  // move covering range to slot 0
		CMD_ADVANCE = 4'd7,  // drop/trim one slot against the ack
		CMD_HSORT   = 4'd8,  // one odd-even pass over the scratch copy for holes
		CMD_HSTEP   = 4'd9,  // examine one scratch slot
		CMD_SINGLE  = 4'd10  // build the single result
	} cmd_t;

	typedef struct packed {
		logic       busy_done;  // current step loop finished
		logic [2:0] func;
		logic       hole_hit;   // current hole step produced a hole
		logic       hole_end;   // no more hole steps possible
	} dp_status_t;
endpackage
`default_nettype wire

// ===== hdl/sack_datapath.sv =====
`default_nettype none
module sack_datapath #(
	parameter int SLOT_COUNT = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sack_pkg::cmd_t      cmd,
	input  wire logic [2:0]          in_func,
	input  wire logic [31:0]         in_left,
	input  wire logic [31:0]         in_right,
	input  wire logic [31:0]         in_ack,
	input  wire logic [31:0]         in_query,
	input  wire logic [2:0]          in_limit,
	input  wire logic                out_load,
	output sack_pkg::dp_status_t     status,
	output logic [69:0]              out_word
);
	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);

	logic [31:0] lo_q [SLOT_COUNT];
	logic [31:0] hi_q [SLOT_COUNT];
	logic [31:0] slo_q [SLOT_COUNT];  // scratch copy sorted for holes
	logic [31:0] shi_q [SLOT_COUNT];
	logic [CW-1:0] used_q;
	logic [31:0] ack_q;
	logic [2:0]  func_q;
	logic [31:0] nl_q, nr_q, na_q, nq_q;
	logic [2:0]  lim_q;
	logic [CW:0] step_q;   // step counter for the iterative loops
	logic [CW-1:0] k_q;    // merge write index / advance write index
	logic [31:0] cur_q;
	logic [2:0]  nh_q;
	logic        cov;
	logic [IW-1:0] pick;
	logic        pick_ok;
	logic [CW:0] nsort;
	logic [2:0]  cap;
	logic [IW-1:0] si;
	logic [31:0] la_cur;
	logic        later;

	assign cap = (lim_q < sack_pkg::RESULT_CAP) ? lim_q : sack_pkg::RESULT_CAP;
	assign nsort = {1'b0, used_q};
	assign si = step_q[IW-1:0];

	// search the covering range and the query answer
	always_comb begin
		cov = 1'b0;
		pick = '0;
		pick_ok = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (i < int'(used_q)) begin
				if (nq_q >= lo_q[i] && nq_q < hi_q[i]) cov = 1'b1;
				if (!pick_ok && lo_q[i] <= nl_q && hi_q[i] >= nr_q) begin
					pick = IW'(i);
					pick_ok = 1'b1;
				end
			end
		end
	end

	// look ahead for a hole beyond the current scratch slot
	always_comb begin
		la_cur = cur_q;
		if (step_q < nsort && shi_q[si] > cur_q) la_cur = shi_q[si];
		later = 1'b0;
		for (int j = 0; j < SLOT_COUNT; j++) begin
			if (j > int'(step_q) && j < int'(used_q)) begin
				if (slo_q[j] > la_cur) later = 1'b1;
				if (shi_q[j] > la_cur) la_cur = shi_q[j];
			end
		end
	end

	// loop-done and hole flags per command
	always_comb begin
		status.func = func_q;
		status.busy_done = 1'b0;
		status.hole_hit = 1'b0;
		status.hole_end = 1'b0;
		case (cmd)
			sack_pkg::CMD_SORT,
			sack_pkg::CMD_HSORT:   status.busy_done = (step_q + 1'b1 >= nsort);
			sack_pkg::CMD_MERGE,
			sack_pkg::CMD_ADVANCE: status.busy_done = (step_q + 1'b1 >= nsort);
			sack_pkg::CMD_HSTEP: begin
				status.hole_hit = (step_q < nsort) && (nh_q < cap) && (slo_q[si] > cur_q);
				status.hole_end = (step_q + 1'b1 >= nsort)
					|| (nh_q + 3'(status.hole_hit) >= cap)
					|| (status.hole_hit && !later);
			end
			default: ;
		endcase
	end

	// execute datapath commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				lo_q[i] <= '0;
				hi_q[i] <= '0;
				slo_q[i] <= '0;
				shi_q[i] <= '0;
			end
			used_q <= '0;
			ack_q <= '0;
			func_q <= '0;
			nl_q <= '0;
			nr_q <= '0;
			na_q <= '0;
			nq_q <= '0;
			lim_q <= '0;
			step_q <= '0;
			k_q <= '0;
			cur_q <= '0;
			nh_q <= '0;
		end else begin
			case (cmd)
				sack_pkg::CMD_LOAD: begin
					func_q <= in_func;
					nl_q <= in_left;
					nr_q <= in_right;
					na_q <= in_ack;
					nq_q <= in_query;
					lim_q <= in_limit;
					step_q <= '0;
					k_q <= '0;
					nh_q <= '0;
					cur_q <= ack_q;
					for (int i = 0; i < SLOT_COUNT; i++) begin
						slo_q[i] <= lo_q[i];
						shi_q[i] <= hi_q[i];
					end
				end
				sack_pkg::CMD_INIT: begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						lo_q[i] <= '0;
						hi_q[i] <= '0;
					end
					used_q <= '0;
					ack_q <= na_q;
				end
				sack_pkg::CMD_INSERT: begin
					if (int'(used_q) < SLOT_COUNT) begin
						lo_q[used_q[IW-1:0]] <= nl_q;
						hi_q[used_q[IW-1:0]] <= nr_q;
						used_q <= used_q + 1'b1;
					end else begin
						lo_q[SLOT_COUNT-1] <= nl_q;
						hi_q[SLOT_COUNT-1] <= nr_q;
					end
					step_q <= '0;
				end
				sack_pkg::CMD_SORT, sack_pkg::CMD_HSORT: begin
					// odd-even pass: stable compare-swap of disjoint pairs
					for (int i = 0; i + 1 < SLOT_COUNT; i++) begin
						if ((i % 2) == int'(step_q[0]) && i + 1 < int'(used_q)) begin
							if (cmd == sack_pkg::CMD_SORT && lo_q[i] > lo_q[i+1]) begin
								lo_q[i] <= lo_q[i+1];
								hi_q[i] <= hi_q[i+1];
								lo_q[i+1] <= lo_q[i];
								hi_q[i+1] <= hi_q[i];
							end
							if (cmd == sack_pkg::CMD_HSORT && slo_q[i] > slo_q[i+1]) begin
								slo_q[i] <= slo_q[i+1];
								shi_q[i] <= shi_q[i+1];
								slo_q[i+1] <= slo_q[i];
								shi_q[i+1] <= shi_q[i];
							end
						end
					end
					// merge walk starts at slot 1, hole walk at slot 0
					step_q <= !status.busy_done ? step_q + 1'b1
						: (cmd == sack_pkg::CMD_SORT) ? {{CW{1'b0}}, 1'b1} : '0;
					k_q <= '0;
				end
				sack_pkg::CMD_MERGE: begin
					// step_q walks i from 1; k_q is the write slot
					if (step_q < nsort) begin
						if (lo_q[si] <= hi_q[k_q[IW-1:0]]) begin
							if (hi_q[si] > hi_q[k_q[IW-1:0]]) hi_q[k_q[IW-1:0]] <= hi_q[si];
						end else begin
							lo_q[IW'(k_q + 1'b1)] <= lo_q[si];
							hi_q[IW'(k_q + 1'b1)] <= hi_q[si];
							k_q <= k_q + 1'b1;
						end
					end
					step_q <= step_q + 1'b1;
				end
				sack_pkg::CMD_FRONT: begin
					if (used_q > 1) used_q <= k_q + 1'b1;
					step_q <= '0;
				end
				sack_pkg::CMD_ADVANCE: begin
					if (na_q > ack_q && step_q < nsort) begin
						if (hi_q[si] > na_q) begin
							lo_q[k_q[IW-1:0]] <= (lo_q[si] < na_q) ? na_q : lo_q[si];
							hi_q[k_q[IW-1:0]] <= hi_q[si];
							k_q <= k_q + 1'b1;
						end
					end
					step_q <= step_q + 1'b1;
					if (status.busy_done && na_q > ack_q) begin
						ack_q <= na_q;
						used_q <= (step_q < nsort && hi_q[si] > na_q) ? k_q + 1'b1 : k_q;
					end
				end
				sack_pkg::CMD_HSTEP: begin
					if (status.hole_hit) nh_q <= nh_q + 1'b1;
					if (step_q < nsort && shi_q[si] > cur_q) cur_q <= shi_q[si];
					step_q <= step_q + 1'b1;
				end
				default: ;
			endcase
			// rotate the covering range to the front after a merge
			if (cmd == sack_pkg::CMD_FRONT && pick_ok && pick != '0) begin
				for (int i = 1; i < SLOT_COUNT; i++)
					if (i <= int'(pick)) begin
						lo_q[i] <= lo_q[i-1];
						hi_q[i] <= hi_q[i-1];
					end
				lo_q[0] <= lo_q[pick];
				hi_q[0] <= hi_q[pick];
			end
		end
	end

	// build result word: count, covered, valid, start, end, last
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cmd == sack_pkg::CMD_HSTEP)
				out_word <= {status.hole_end, slo_q[si], cur_q, 1'b1, 1'b0, 3'(used_q)};
			else
				out_word <= {1'b1, 64'd0, 1'b0,
					(func_q == sack_pkg::FUNC_QUERY) ? cov : 1'b0, 3'(used_q)};
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sack_ctrl.sv =====
`default_nettype none
module sack_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_go,
	input  wire sack_pkg::dp_status_t status,
	input  wire logic               out_free,
	output logic                    s_ready,
	output sack_pkg::cmd_t          cmd,
	output logic                    out_load
);
	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001, ST_DISP = 8'b00000010, ST_SORT = 8'b00000100,
		ST_MERGE = 8'b00001000, ST_FRONT = 8'b00010000, ST_ADV = 8'b00100000,
		ST_HOLE = 8'b01000000, ST_DONE = 8'b10000000
	} state_t;
	state_t state_q, state_d;
	logic   any_hole_q;

	assign s_ready = (state_q == ST_IDLE);

	// sequence the datapath steps for one item
	always_comb begin
		state_d = state_q;
		cmd = sack_pkg::CMD_NONE;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: if (s_go) begin
				cmd = sack_pkg::CMD_LOAD;
				state_d = ST_DISP;
			end
			ST_DISP: begin
				case (status.func)
					sack_pkg::FUNC_INIT: begin cmd = sack_pkg::CMD_INIT; state_d = ST_DONE; end
					sack_pkg::FUNC_ADD: begin cmd = sack_pkg::CMD_INSERT; state_d = ST_SORT; end
					sack_pkg::FUNC_ADVANCE: state_d = ST_ADV;
					sack_pkg::FUNC_HOLES: begin cmd = sack_pkg::CMD_HSORT; state_d = ST_SORT; end
					default: state_d = ST_DONE;
				endcase
			end
			ST_SORT: begin
				cmd = (status.func == sack_pkg::FUNC_HOLES) ? sack_pkg::CMD_HSORT
					: sack_pkg::CMD_SORT;
				if (status.busy_done)
					state_d = (status.func == sack_pkg::FUNC_HOLES) ? ST_HOLE : ST_MERGE;
			end
			ST_MERGE: begin
				cmd = sack_pkg::CMD_MERGE;
				if (status.busy_done) state_d = ST_FRONT;
			end
			ST_FRONT: begin cmd = sack_pkg::CMD_FRONT; state_d = ST_DONE; end
			ST_ADV: begin
				cmd = sack_pkg::CMD_ADVANCE;
				if (status.busy_done) state_d = ST_DONE;
			end
			ST_HOLE: if (out_free) begin
				cmd = sack_pkg::CMD_HSTEP;
				if (status.hole_hit) out_load = 1'b1;
				if (status.hole_end)
					state_d = (status.hole_hit || any_hole_q) ? ST_IDLE : ST_DONE;
			end
			ST_DONE: if (out_free) begin
				cmd = sack_pkg::CMD_SINGLE;
				out_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold state and remember whether a hole went out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			any_hole_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) any_hole_q <= 1'b0;
			else if (out_load) any_hole_q <= 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sack_scoreboard_top.sv =====
// Scoreboard of up to SLOT_COUNT ranges with a cumulative ack, one item at a time.
// Each item goes from idle to dispatch; init, query and unknown functions then go to done.
// Advance walks the stored ranges; add stores the range, then sorts, merges and fronts the table;
// holes sorts a scratch copy, examines one range per step and goes to done only when no hole.
// A new item is taken only back in idle; output stalls hold the hole and done states.
// Reset clears the table, the ack, the controller and the output valid flag.
`default_nettype none
module sack_scoreboard_top #(
	parameter int SLOT_COUNT = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [135:0] s_tdata,  // func[2:0] left_edge right_edge ack_value query_seq hole_limit, pad
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [71:0]       m_tdata,  // block_count[2:0] is_covered hole_valid hole_start hole_end, pad
	output logic              m_tlast
);
	sack_pkg::cmd_t       cmd;
	sack_pkg::dp_status_t status;
	logic                 out_load, out_free;
	logic [69:0]          word;
	logic                 valid_q;

	assign out_free = !valid_q || m_tready;

	sack_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_go(s_tvalid), .status(status),
		.out_free(out_free), .s_ready(s_tready), .cmd(cmd), .out_load(out_load)
	);

	sack_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_func(s_tdata[2:0]), .in_left(s_tdata[34:3]), .in_right(s_tdata[66:35]),
		.in_ack(s_tdata[98:67]), .in_query(s_tdata[130:99]), .in_limit(s_tdata[133:131]),
		.out_load(out_load), .status(status), .out_word(word)
	);

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (out_load) valid_q <= 1'b1;
		else if (m_tready) valid_q <= 1'b0;
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {3'b0, word[68:0]};
	assign m_tlast = word[69];

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!valid_q || m_tready)) else $error("result overrun");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !out_load) else $error("result while idle");
`endif
endmodule
`default_nettype wire

// ===== tb/sack_scoreboard_top_tb.sv =====
`default_nettype none
module sack_scoreboard_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [2:0] FUNC_RSVD_LO = 3'd5;
	localparam logic [2:0] FUNC_RSVD_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] left_edge;
		logic [31:0] right_edge;
		logic [31:0] ack_value;
		logic [31:0] query_seq;
		logic [2:0]  hole_limit;
	} sack_op_t;

	typedef struct packed {
		logic [2:0]  block_count;
		logic        is_covered;
		logic        hole_valid;
		logic [31:0] hole_start;
		logic [31:0] hole_end;
		logic        last;
	} sack_res_t;

	typedef struct {
		sack_op_t  op;
		logic      typed;
		sack_res_t res;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic         m_tlast;

	sack_scoreboard_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// shadow scoreboard
	logic [31:0] sb_lo [NSLOT];
	logic [31:0] sb_hi [NSLOT];
	int unsigned sb_used;
	logic [31:0] sb_ack;

	sack_res_t   pending_res[$];
	int          fail_count;
	int          res_seen;
	int          hole_seen;
	longint      cycles = 0;
	logic        stall_hold;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		fail_count++;
		$display("mismatch at result %0d: %s got %0h want %0h", res_seen, what, got, want);
	endtask

	function automatic sack_res_t single_res(input logic covered);
		sack_res_t r;
		r = '0;
		r.block_count = sb_used[2:0];
		r.is_covered = covered;
		r.last = 1'b1;
		return r;
	endfunction

	// sort by left edge (stable insertion)
	task automatic order_by_left(inout logic [31:0] lo[NSLOT], inout logic [31:0] hi[NSLOT],
			input int unsigned n);
		int j;
		logic [31:0] tl, th;
		for (int i = 1; i < n; i++) begin
			tl = lo[i];
			th = hi[i];
			j = i;
			while (j > 0 && lo[j-1] > tl) begin
				lo[j] = lo[j-1];
				hi[j] = hi[j-1];
				j--;
			end
			lo[j] = tl;
			hi[j] = th;
		end
	endtask

	task automatic insert_range(input logic [31:0] lo, input logic [31:0] hi);
		int unsigned k;
		int unsigned pick;
		logic [31:0] tl, th;
		k = 0;
		pick = 0;
		if (sb_used < NSLOT) begin
			sb_lo[sb_used] = lo;
			sb_hi[sb_used] = hi;
			sb_used++;
		end else begin
			sb_lo[NSLOT-1] = lo;
			sb_hi[NSLOT-1] = hi;
		end
		// fold overlapping or touching ranges
		if (sb_used > 1) begin
			order_by_left(sb_lo, sb_hi, sb_used);
			for (int i = 1; i < sb_used; i++) begin
				if (sb_lo[i] <= sb_hi[k]) begin
					if (sb_hi[i] > sb_hi[k]) sb_hi[k] = sb_hi[i];
				end else begin
					k++;
					sb_lo[k] = sb_lo[i];
					sb_hi[k] = sb_hi[i];
				end
			end
			sb_used = k + 1;
		end
		// bring the covering range to the front
		for (int i = 0; i < sb_used; i++) begin
			if (sb_lo[i] <= lo && sb_hi[i] >= hi) begin
				pick = i;
				break;
			end
		end
		if (pick != 0) begin
			tl = sb_lo[pick];
			th = sb_hi[pick];
			for (int i = pick; i > 0; i--) begin
				sb_lo[i] = sb_lo[i-1];
				sb_hi[i] = sb_hi[i-1];
			end
			sb_lo[0] = tl;
			sb_hi[0] = th;
		end
	endtask

	task automatic predict_op(input sack_op_t op);
		int unsigned w;
		int unsigned cap;
		int unsigned nh;
		logic [31:0] cur;
		logic [31:0] tlo [NSLOT];
		logic [31:0] thi [NSLOT];
		logic covered;
		sack_res_t r;
		w = 0;
		nh = 0;
		covered = 1'b0;
		case (op.func)
			sack_pkg::FUNC_INIT: begin
				for (int i = 0; i < NSLOT; i++) begin
					sb_lo[i] = '0;
					sb_hi[i] = '0;
				end
				sb_used = 0;
				sb_ack = op.ack_value;
			end
			sack_pkg::FUNC_ADD: insert_range(op.left_edge, op.right_edge);
			sack_pkg::FUNC_ADVANCE: begin
				if (op.ack_value > sb_ack) begin
					sb_ack = op.ack_value;
					for (int i = 0; i < sb_used; i++) begin
						if (sb_hi[i] > sb_ack) begin
							sb_lo[w] = (sb_lo[i] < sb_ack) ? sb_ack : sb_lo[i];
							sb_hi[w] = sb_hi[i];
							w++;
						end
					end
					sb_used = w;
				end
			end
			sack_pkg::FUNC_QUERY: begin
				for (int i = 0; i < sb_used; i++)
					if (op.query_seq >= sb_lo[i] && op.query_seq < sb_hi[i]) covered = 1'b1;
			end
			sack_pkg::FUNC_HOLES: begin
				cap = (op.hole_limit < sack_pkg::RESULT_CAP) ? op.hole_limit
					: sack_pkg::RESULT_CAP;
				tlo = sb_lo;
				thi = sb_hi;
				order_by_left(tlo, thi, sb_used);
				cur = sb_ack;
				for (int i = 0; i < sb_used && nh < cap; i++) begin
					if (tlo[i] > cur) begin
						r = '0;
						r.block_count = sb_used[2:0];
						r.hole_valid = 1'b1;
						r.hole_start = cur;
						r.hole_end = tlo[i];
						pending_res.push_back(r);
						nh++;
					end
					if (thi[i] > cur) cur = thi[i];
				end
				if (nh > 0) begin
					pending_res[$].last = 1'b1;
					return;
				end
			end
			default: ;
		endcase
		pending_res.push_back(single_res(covered));
	endtask

	// clock and cycle watchdog
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_hold) begin
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		stall_hold = 1'b0;
		@(posedge arst_n);
		repeat (400) @(posedge clk);
		stall_hold = 1'b1;
		repeat (300) @(posedge clk);
		stall_hold = 1'b0;
	end

	// result checker
	always @(posedge clk) begin
		sack_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.block_count = m_tdata[2:0];
			got.is_covered = m_tdata[3];
			got.hole_valid = m_tdata[4];
			got.hole_start = m_tdata[36:5];
			got.hole_end = m_tdata[68:37];
			got.last = m_tlast;
			res_seen++;
			if (got.hole_valid) hole_seen++;
			if (pending_res.size() == 0) begin
				report("unexpected result", 32'(res_seen), 32'd0);
			end else begin
				want = pending_res.pop_front();
				if (got.block_count !== want.block_count)
					report("block_count", 32'(got.block_count), 32'(want.block_count));
				if (got.is_covered !== want.is_covered)
					report("is_covered", 32'(got.is_covered), 32'(want.is_covered));
				if (got.hole_valid !== want.hole_valid)
					report("hole_valid", 32'(got.hole_valid), 32'(want.hole_valid));
				if (got.hole_start !== want.hole_start)
					report("hole_start", got.hole_start, want.hole_start);
				if (got.hole_end !== want.hole_end)
					report("hole_end", got.hole_end, want.hole_end);
				if (got.last !== want.last)
					report("last", 32'(got.last), 32'(want.last));
			end
		end
	end

	task automatic send_op(input sack_op_t op);
		int gap;
		if ($urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {{(136 - $bits(sack_op_t)){1'b0}}, op.hole_limit, op.query_seq,
			op.ack_value, op.right_edge, op.left_edge, op.func};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_op(op);
		@(negedge clk);
	endtask

	function automatic sack_op_t mk_op(input logic [2:0] f, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d,
			input logic [2:0] l);
		sack_op_t op;
		op.func = f;
		op.left_edge = a;
		op.right_edge = b;
		op.ack_value = c;
		op.query_seq = d;
		op.hole_limit = l;
		return op;
	endfunction

	function automatic sack_res_t mk_res(input logic [2:0] n, input logic cov);
		sack_res_t r;
		r = '0;
		r.block_count = n;
		r.is_covered = cov;
		r.last = 1'b1;
		return r;
	endfunction

	// random op, mostly a coherent window around a base sequence number
	function automatic sack_op_t rand_op(input logic [31:0] base);
		sack_op_t op;
		logic [31:0] a;
		op = mk_op(3'($urandom_range(0, 9) < 9 ? $urandom_range(1, 4) : $urandom_range(0, 7)),
			$urandom, $urandom, $urandom, $urandom, 3'($urandom_range(0, 7)));
		if ($urandom_range(0, 9) < 8) begin
			a = base + $urandom_range(0, 400);
			op.left_edge = a;
			op.right_edge = a + $urandom_range(0, 60);
			if ($urandom_range(0, 15) == 0) op.right_edge = a - $urandom_range(1, 5);
			op.ack_value = base + $urandom_range(0, 300);
			op.query_seq = base + $urandom_range(0, 460);
		end
		return op;
	endfunction

	initial begin
		stim_row_t rows[$];
		sack_op_t op;
		logic [31:0] base;
		int n_dir;
		int wait_n;
		fail_count = 0;
		res_seen = 0;
		hole_seen = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		sb_used = 0;
		sb_ack = '0;
		for (int i = 0; i < NSLOT; i++) begin
			sb_lo[i] = '0;
			sb_hi[i] = '0;
		end
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table: typed answers where obvious, predictor elsewhere
		rows.push_back('{mk_op(sack_pkg::FUNC_QUERY, 0, 0, 0, 0, 3'd0), 1'b1,
			mk_res(3'd0, 1'b0)});
		rows.push_back('{mk_op(sack_pkg::FUNC_HOLES, 0, 0, 0, 0, 3'd4), 1'b1,
			mk_res(3'd0, 1'b0)});
		rows.push_back('{mk_op(FUNC_RSVD_LO, '1, '1, '1, '1, 3'd7), 1'b1, mk_res(3'd0, 1'b0)});
		rows.push_back('{mk_op(sack_pkg::FUNC_INIT, 0, 0, 32'd100, 0, 3'd0), 1'b1,
			mk_res(3'd0, 1'b0)});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADD, 200, 300, 0, 0, 3'd0), 1'b1,
			mk_res(3'd1, 1'b0)});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADD, 400, 500, 0, 0, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADD, 300, 350, 0, 0, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADD, 600, 600, 0, 0, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADD, 800, 700, 0, 0, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADD, 900, 950, 0, 0, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_QUERY, 0, 0, 0, 349, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_QUERY, 0, 0, 0, 350, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_HOLES, 0, 0, 0, 0, 3'd7), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_HOLES, 0, 0, 0, 0, 3'd2), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_HOLES, 0, 0, 0, 0, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADVANCE, 0, 0, 32'd50, 0, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADVANCE, 0, 0, 32'd420, 0, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_HOLES, 0, 0, 0, 0, 3'd4), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADD, '1, '1, 0, 0, 3'd0), 1'b0, '0});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADVANCE, 0, 0, '1, 0, 3'd0), 1'b1,
			mk_res(3'd0, 1'b0)});
		rows.push_back('{mk_op(sack_pkg::FUNC_INIT, 0, 0, 0, 0, 3'd0), 1'b1,
			mk_res(3'd0, 1'b0)});
		rows.push_back('{mk_op(sack_pkg::FUNC_ADD, 0, '1, 0, 0, 3'd0), 1'b1,
			mk_res(3'd1, 1'b0)});
		rows.push_back('{mk_op(sack_pkg::FUNC_QUERY, 0, 0, 0, '1, 3'd0), 1'b1,
			mk_res(3'd1, 1'b0)});
		rows.push_back('{mk_op(FUNC_RSVD_HI, 0, 0, 0, 0, 3'd0), 1'b1, mk_res(3'd1, 1'b0)});
		n_dir = rows.size();
		foreach (rows[i]) begin
			send_op(rows[i].op);
			if (rows[i].typed && (pending_res.size() == 0 || pending_res[$] != rows[i].res))
				report($sformatf("typed answer of row %0d", i),
					32'(pending_res[$].block_count), 32'(rows[i].res.block_count));
		end

		// random part: windows of well-formed traffic, occasional init
		base = $urandom;
		for (int i = 0; i < 270; i++) begin
			if ($urandom_range(0, 29) == 0) begin
				base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FE00 : $urandom;
				op = mk_op(sack_pkg::FUNC_INIT, $urandom, $urandom, base, $urandom,
					3'($urandom_range(0, 7)));
			end else begin
				op = rand_op(base);
			end
			send_op(op);
		end
		s_tvalid <= 1'b0;

		wait_n = 0;
		while (pending_res.size() != 0) @(posedge clk);
		while (wait_n < 50) begin
			@(posedge clk);
			wait_n++;
		end
		$display("ran %0d directed and 270 random items, %0d results, %0d holes",
			n_dir, res_seen, hole_seen);
		if (fail_count == 0 && pending_res.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("failures: %0d, results left waiting: %0d", fail_count, pending_res.size());
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
